FILE: sv/ews_pkg.sv
// Shared widths, reset values and codes for the emission window statistics block.
package ews_pkg;

    localparam int NOISE_W       = 11;
    localparam int TEMP_W        = 12;
    localparam int POWER_W       = 16;
    localparam int COUNT_W       = 9;
    localparam int CFG_DATA_W    = 12;
    localparam int MAX_SAMPLES_DEF = 256;
    localparam int COUNT_SAT     = 511;

    localparam logic [NOISE_W-1:0]       NOISE_LIMIT_RST   = 11'd850;
    localparam logic signed [TEMP_W-1:0] THERMAL_LIMIT_RST = 12'sd450;
    localparam logic signed [TEMP_W-1:0] TEMP_MOST_NEG     = 12'sh800;

    typedef enum logic
    {
        REG_NOISE_LIMIT   = 1'b0,
        REG_THERMAL_LIMIT = 1'b1
    } reg_index_t;

    typedef enum logic [1:0]
    {
        VIOL_NONE    = 2'd0,
        VIOL_ESTOP   = 2'd1,
        VIOL_NOISE   = 2'd2,
        VIOL_THERMAL = 2'd3
    } violation_t;

endpackage

FILE: sv/ews_div.sv
// Restoring divider, one quotient bit per cycle.
module ews_div #(
    parameter int DIVIDEND_W = 25,
    parameter int DIVISOR_W  = 9
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dsr_reg;

    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W+1:0]  diff;
    logic                  ge;
    logic [DIVISOR_W-1:0]  rem_next;

    assign shifted  = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff     = {1'b0, shifted} - {2'b00, dsr_reg};
    assign ge       = !diff[DIVISOR_W+1];
    assign rem_next = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVIDEND_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(DIVIDEND_W + 1) done)
        else $error("divider done not on time");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy_reg)
        else $error("divider done while busy");
`endif

endmodule

FILE: sv/emission_window_statistics.sv
// Top level: window accumulators, limit registers, divide sequencer and result register.
//
//  channel   direction  handshake              payload
//  sample    in         sample_valid/stall     noise_level temperature power_draw e_stop last_sample
//  result    out        result_valid/stall     avg_* noise_max max_temperature sample_count violation
//  cfg       in         cfg_valid/cfg_ready    cfg_index cfg_data
//
// A plain sample is accumulated without leaving the idle state. A last sample runs
// three divides on one shared restoring divider of 16+clog2(MAX_SAMPLES+1) bits;
// an e_stop sample skips them and goes straight to the final state. Reset loads the
// limits with 850 and 450 and clears the window. While the result register is
// stalled, a finished window waits in the final state and samples are stalled.
module emission_window_statistics
    import ews_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     sample_valid,
    output logic                     sample_stall,
    input  logic [NOISE_W-1:0]       noise_level,
    input  logic signed [TEMP_W-1:0] temperature,
    input  logic [POWER_W-1:0]       power_draw,
    input  logic                     e_stop,
    input  logic                     last_sample,
    output logic                     result_valid,
    input  logic                     result_stall,
    output logic [NOISE_W-1:0]       avg_noise,
    output logic signed [TEMP_W-1:0] avg_temperature,
    output logic [POWER_W-1:0]       avg_power,
    output logic [NOISE_W-1:0]       noise_max,
    output logic signed [TEMP_W-1:0] max_temperature,
    output logic [COUNT_W-1:0]       sample_count,
    output logic [1:0]               violation,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic                     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    localparam int CW  = $clog2(MAX_SAMPLES + 1);
    localparam int NSW = NOISE_W + CW;
    localparam int TSW = TEMP_W + CW;
    localparam int PSW = POWER_W + CW;
    localparam int DW  = PSW;
    localparam int TW  = (CW > COUNT_W) ? CW : COUNT_W;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_START,
        S_WAIT,
        S_FINISH
    } state_t;

    typedef enum logic [1:0]
    {
        OP_NOISE,
        OP_TEMP,
        OP_POWER
    } op_t;

    state_t                   state_reg;
    op_t                      op_reg;
    logic                     estop_reg;

    logic [NOISE_W-1:0]       noise_limit_reg;
    logic signed [TEMP_W-1:0] thermal_limit_reg;

    logic [NSW-1:0]           noise_sum_reg;
    logic signed [TSW-1:0]    temp_sum_reg;
    logic [PSW-1:0]           power_sum_reg;
    logic [NOISE_W-1:0]       noise_peak_reg;
    logic signed [TEMP_W-1:0] temp_peak_reg;
    logic [CW-1:0]            tally_reg;

    logic [NOISE_W-1:0]       q_noise_reg;
    logic [TEMP_W-1:0]        q_temp_reg;
    logic [POWER_W-1:0]       q_power_reg;

    logic                     result_valid_reg;
    logic [NOISE_W-1:0]       avg_noise_reg;
    logic signed [TEMP_W-1:0] avg_temp_reg;
    logic [POWER_W-1:0]       avg_power_reg;
    logic [NOISE_W-1:0]       noise_max_reg;
    logic signed [TEMP_W-1:0] max_temp_reg;
    logic [COUNT_W-1:0]       count_reg;
    logic [1:0]               violation_reg;

    logic                     sample_accept;
    logic                     room;
    logic                     out_free;
    logic                     div_start;
    logic                     div_done;
    logic [DW-1:0]            div_dividend;
    logic [DW-1:0]            div_quotient;
    logic [TSW-1:0]           temp_mag;
    logic                     temp_neg;
    logic [TW-1:0]            tally_ext;
    logic [COUNT_W-1:0]       count_sat;
    logic [1:0]               code;

    assign sample_stall  = (state_reg != S_IDLE);
    assign sample_accept = sample_valid && !sample_stall;
    assign room          = (tally_reg < CW'(MAX_SAMPLES));
    assign out_free      = !result_valid_reg || !result_stall;
    assign cfg_ready     = 1'b1;

    assign temp_neg  = temp_sum_reg[TSW-1];
    assign temp_mag  = temp_neg ? TSW'(-temp_sum_reg) : TSW'(temp_sum_reg);
    assign tally_ext = TW'(tally_reg);
    assign count_sat = (tally_ext > TW'(COUNT_SAT)) ? COUNT_W'(COUNT_SAT)
                                                    : tally_ext[COUNT_W-1:0];

    always_comb
    begin
        case (op_reg)
            OP_NOISE: div_dividend = DW'(noise_sum_reg);
            OP_TEMP:  div_dividend = DW'(temp_mag);
            OP_POWER: div_dividend = DW'(power_sum_reg);
            default:  div_dividend = '0;
        endcase
    end

    always_comb
    begin
        code = VIOL_NONE;
        if (noise_peak_reg > noise_limit_reg)
            code = VIOL_NOISE;
        if (temp_peak_reg > thermal_limit_reg)
            code = VIOL_THERMAL;
    end

    assign div_start = (state_reg == S_START);

    ews_div #(
        .DIVIDEND_W (DW),
        .DIVISOR_W  (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (tally_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_limit_reg   <= NOISE_LIMIT_RST;
            thermal_limit_reg <= THERMAL_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (reg_index_t'(cfg_index))
                REG_NOISE_LIMIT:   noise_limit_reg   <= cfg_data[NOISE_W-1:0];
                REG_THERMAL_LIMIT: thermal_limit_reg <= cfg_data[TEMP_W-1:0];
                default:           noise_limit_reg   <= noise_limit_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            op_reg           <= OP_NOISE;
            estop_reg        <= 1'b0;
            noise_sum_reg    <= '0;
            temp_sum_reg     <= '0;
            power_sum_reg    <= '0;
            noise_peak_reg   <= '0;
            temp_peak_reg    <= TEMP_MOST_NEG;
            tally_reg        <= '0;
            q_noise_reg      <= '0;
            q_temp_reg       <= '0;
            q_power_reg      <= '0;
            result_valid_reg <= 1'b0;
            avg_noise_reg    <= '0;
            avg_temp_reg     <= '0;
            avg_power_reg    <= '0;
            noise_max_reg    <= '0;
            max_temp_reg     <= '0;
            count_reg        <= '0;
            violation_reg    <= VIOL_NONE;
        end
        else
        begin
            if (result_valid_reg && !result_stall && (state_reg != S_FINISH))
                result_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (sample_accept)
                    begin
                        estop_reg <= e_stop;
                        op_reg    <= OP_NOISE;
                        if (e_stop)
                        begin
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            if (room)
                            begin
                                noise_sum_reg <= noise_sum_reg + NSW'(noise_level);
                                temp_sum_reg  <= temp_sum_reg + TSW'(temperature);
                                power_sum_reg <= power_sum_reg + PSW'(power_draw);
                                if (noise_level > noise_peak_reg)
                                    noise_peak_reg <= noise_level;
                                if (temperature > temp_peak_reg)
                                    temp_peak_reg <= temperature;
                                tally_reg <= tally_reg + 1'b1;
                            end
                            if (last_sample)
                                state_reg <= S_START;
                        end
                    end
                end

                S_START:
                begin
                    state_reg <= S_WAIT;
                end

                S_WAIT:
                begin
                    if (div_done)
                    begin
                        case (op_reg)
                            OP_NOISE:
                            begin
                                q_noise_reg <= div_quotient[NOISE_W-1:0];
                                op_reg      <= OP_TEMP;
                                state_reg   <= S_START;
                            end
                            OP_TEMP:
                            begin
                                q_temp_reg <= temp_neg ? TEMP_W'(-div_quotient[TEMP_W-1:0])
                                                       : div_quotient[TEMP_W-1:0];
                                op_reg     <= OP_POWER;
                                state_reg  <= S_START;
                            end
                            default:
                            begin
                                q_power_reg <= div_quotient[POWER_W-1:0];
                                state_reg   <= S_FINISH;
                            end
                        endcase
                    end
                end

                S_FINISH:
                begin
                    if (out_free)
                    begin
                        result_valid_reg <= 1'b1;
                        if (estop_reg || (tally_reg == '0))
                        begin
                            avg_noise_reg <= '0;
                            avg_temp_reg  <= '0;
                            avg_power_reg <= '0;
                        end
                        else
                        begin
                            avg_noise_reg <= q_noise_reg;
                            avg_temp_reg  <= q_temp_reg;
                            avg_power_reg <= q_power_reg;
                        end
                        if (estop_reg)
                        begin
                            noise_max_reg <= '0;
                            max_temp_reg  <= '0;
                            count_reg     <= '0;
                            violation_reg <= VIOL_ESTOP;
                        end
                        else
                        begin
                            noise_max_reg <= noise_peak_reg;
                            max_temp_reg  <= temp_peak_reg;
                            count_reg     <= count_sat;
                            violation_reg <= code;
                        end
                        noise_sum_reg  <= '0;
                        temp_sum_reg   <= '0;
                        power_sum_reg  <= '0;
                        noise_peak_reg <= '0;
                        temp_peak_reg  <= TEMP_MOST_NEG;
                        tally_reg      <= '0;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid    = result_valid_reg;
    assign avg_noise       = avg_noise_reg;
    assign avg_temperature = avg_temp_reg;
    assign avg_power       = avg_power_reg;
    assign noise_max       = noise_max_reg;
    assign max_temperature = max_temp_reg;
    assign sample_count    = count_reg;
    assign violation       = violation_reg;

`ifndef SYNTHESIS
    a_tally_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tally_reg <= CW'(MAX_SAMPLES))
        else $error("sample tally beyond window size");
    a_estop_finish: assert property (@(posedge clk) disable iff (!rst_n)
        sample_accept && e_stop |=> state_reg == S_FINISH)
        else $error("estop request did not close window");
    a_estop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && violation == VIOL_ESTOP |-> sample_count == '0 && noise_max == '0)
        else $error("estop result carries statistics");
    a_div_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_START |-> !estop_reg)
        else $error("divide started for estop window");
`endif

endmodule
